// File: rtl/tlca_pkg.sv
// Shared constants, payload types and helper types for the common-ancestor engine.
package tlca_pkg;

  localparam int NODES      = 1024;
  localparam int NODE_W     = $clog2(NODES);
  localparam int EDGE_SLOTS = 2048;
  localparam int SLOT_W     = $clog2(EDGE_SLOTS);
  localparam int LINK_W     = SLOT_W + 1;
  localparam int LEVELS     = 11;
  localparam int LVL_W      = $clog2(LEVELS);

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [LINK_W-1:0] link_t;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_ID   = 2'd2;
  localparam logic [1:0] ST_NO_BUILD = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    node_t      node_a;
    node_t      node_b;
  } in_t;

  typedef struct packed {
    node_t      ancestor;
    logic [1:0] status;
  } out_t;

  // One node row: visited mark, depth and its power-of-two ancestors.
  typedef struct packed {
    logic                   visited;
    node_t                  depth;
    node_t [LEVELS-1:0]     anc;
  } row_t;

  typedef struct packed {
    logic  en;
    node_t addr;
    row_t  data;
  } row_wr_t;

endpackage

// File: rtl/tlca_node_ram.sv
// Node row memory: one write port and two registered read ports.
module tlca_node_ram (
  input  logic            clk_i,
  input  tlca_pkg::row_wr_t wr_i,
  input  tlca_pkg::node_t raddr_a_i,
  input  tlca_pkg::node_t raddr_b_i,
  output tlca_pkg::row_t  rdata_a_o,
  output tlca_pkg::row_t  rdata_b_o
);
  import tlca_pkg::*;

  row_t mem [NODES];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// File: rtl/tree_lca_binary_lifting_unit.sv
// Lowest-common-ancestor engine with adjacency lists, stack walk and ancestor rows.
// Load: the edge enters both adjacency lists. Query: two passes over the 11 levels with
// one node-row read per level that lifts or descends, the second only if the nodes differ;
// a refused item goes straight to the output. Build: a node-row clearing sweep, then a
// stack walk filling new rows; one item at a time, the beat waits at the output.
// After reset the block clears all 1024 head entries and node rows with stall high.
module tree_lca_binary_lifting_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  tlca_pkg::node_t cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tlca_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tlca_pkg::out_t out_data_o
);
  import tlca_pkg::*;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_LA1    = 5'd2;
  localparam logic [4:0] S_LA2    = 5'd3;
  localparam logic [4:0] S_LB1    = 5'd4;
  localparam logic [4:0] S_LB2    = 5'd5;
  localparam logic [4:0] S_BROOT  = 5'd6;
  localparam logic [4:0] S_BROOT2 = 5'd7;
  localparam logic [4:0] S_BTOP   = 5'd8;
  localparam logic [4:0] S_BPOP   = 5'd9;
  localparam logic [4:0] S_BEDGE  = 5'd10;
  localparam logic [4:0] S_BVIS   = 5'd11;
  localparam logic [4:0] S_BANC   = 5'd12;
  localparam logic [4:0] S_BANCW  = 5'd13;
  localparam logic [4:0] S_BWR    = 5'd14;
  localparam logic [4:0] S_QRD    = 5'd15;
  localparam logic [4:0] S_QSW    = 5'd16;
  localparam logic [4:0] S_QLIFT  = 5'd17;
  localparam logic [4:0] S_QLIFTW = 5'd18;
  localparam logic [4:0] S_QCMP   = 5'd19;
  localparam logic [4:0] S_QDESC  = 5'd20;
  localparam logic [4:0] S_QDESCW = 5'd21;
  localparam logic [4:0] S_QFIN   = 5'd22;
  localparam logic [4:0] S_DONE   = 5'd23;

  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);
  localparam link_t            FULL_AT = LINK_W'(EDGE_SLOTS - 2);

  typedef struct packed {
    node_t node;
    link_t cur;
    node_t dep;
  } frame_t;

  logic [4:0]        state_q, state_d;
  logic              clr_head_q, clr_head_d;
  node_t             clr_cnt_q, clr_cnt_d;
  node_t             root_q;
  logic              built_q, built_d;
  link_t             used_q, used_d;
  node_t             a_q, a_d, b_q, b_d;
  out_t              res_q, res_d;
  logic              out_valid_q;
  out_t              out_q;
  frame_t            top_q, top_d;
  node_t             sp_q, sp_d;
  node_t             t_q, t_d;
  link_t             new_cur_q, new_cur_d;
  node_t [LEVELS-1:0] new_anc_q, new_anc_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  node_t             u_q, u_d, v_q, v_d;
  row_t              row_u_q, row_u_d, row_v_q, row_v_d;
  logic [LEVELS-1:0] dist_q, dist_d;

  // Memories other than the node rows.
  link_t  head_mem [NODES];
  link_t  next_mem [EDGE_SLOTS];
  node_t  tgt_mem  [EDGE_SLOTS];
  frame_t stack_mem [NODES];

  link_t  head_rdata, next_rdata;
  node_t  tgt_rdata;
  frame_t stack_rdata;

  node_t  head_raddr, head_waddr;
  logic   head_we;
  link_t  head_wdata;
  logic   edge_we;
  node_t  edge_tgt;
  logic [SLOT_W-1:0] edge_raddr;
  logic   stack_we;

  row_wr_t row_wr;
  node_t   raddr_a, raddr_b;
  row_t    rdata_a, rdata_b;

  logic out_free;
  logic accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  tlca_node_ram u_node_ram (
    .clk_i     (clk_i),
    .wr_i      (row_wr),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Memory addressing and write strobes.
  always_comb begin
    head_raddr = a_q;
    head_waddr = a_q;
    head_we    = 1'b0;
    head_wdata = used_q + LINK_W'(1);
    edge_we    = 1'b0;
    edge_tgt   = b_q;
    edge_raddr = SLOT_W'(top_q.cur - LINK_W'(1));
    stack_we   = 1'b0;
    row_wr     = '0;
    raddr_a    = a_q;
    raddr_b    = b_q;
    case (state_q)
      S_CLR: begin
        head_we    = clr_head_q;
        head_waddr = clr_cnt_q;
        head_wdata = '0;
        row_wr.en   = 1'b1;
        row_wr.addr = clr_cnt_q;
      end
      S_LB1: head_raddr = b_q;
      S_LA2: begin
        head_we = 1'b1;
        edge_we = 1'b1;
      end
      S_LB2: begin
        head_we    = 1'b1;
        head_waddr = b_q;
        edge_we    = 1'b1;
        edge_tgt   = a_q;
      end
      S_BROOT: begin
        head_raddr = root_q;
        row_wr.en           = 1'b1;
        row_wr.addr         = root_q;
        row_wr.data.visited = 1'b1;
        row_wr.data.depth   = NODE_W'(1);
      end
      S_BEDGE: begin
        head_raddr = tgt_rdata;
        raddr_a    = tgt_rdata;
      end
      S_BANC: raddr_a = new_anc_q[lvl_q - LVL_W'(1)];
      S_BWR: begin
        stack_we            = 1'b1;
        row_wr.en           = 1'b1;
        row_wr.addr         = t_q;
        row_wr.data.visited = 1'b1;
        row_wr.data.depth   = top_q.dep + NODE_W'(1);
        row_wr.data.anc     = new_anc_q;
      end
      S_QLIFT: raddr_b = row_v_q.anc[lvl_q];
      S_QDESC: begin
        raddr_a = row_u_q.anc[lvl_q];
        raddr_b = row_v_q.anc[lvl_q];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rdata <= head_mem[head_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      next_mem[used_q[SLOT_W-1:0]] <= head_rdata;
      tgt_mem[used_q[SLOT_W-1:0]]  <= edge_tgt;
    end
    next_rdata <= next_mem[edge_raddr];
    tgt_rdata  <= tgt_mem[edge_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[sp_q] <= top_q;
    end
    stack_rdata <= stack_mem[sp_q - NODE_W'(1)];
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    clr_head_d = clr_head_q;
    clr_cnt_d  = clr_cnt_q;
    built_d    = built_q;
    used_d     = used_q;
    a_d        = a_q;
    b_d        = b_q;
    res_d      = res_q;
    top_d      = top_q;
    sp_d       = sp_q;
    t_d        = t_q;
    new_cur_d  = new_cur_q;
    new_anc_d  = new_anc_q;
    lvl_d      = lvl_q;
    u_d        = u_q;
    v_d        = v_q;
    row_u_d    = row_u_q;
    row_v_d    = row_v_q;
    dist_d     = dist_q;
    case (state_q)
      S_CLR: begin
        clr_cnt_d = clr_cnt_q + NODE_W'(1);
        if (clr_cnt_q == NODE_W'(NODES - 1)) begin
          clr_head_d = 1'b0;
          state_d    = clr_head_q ? S_IDLE : S_BROOT;
        end
      end
      S_IDLE: begin
        if (accept) begin
          a_d   = in_data_i.node_a;
          b_d   = in_data_i.node_b;
          res_d = '0;
          case (in_data_i.opcode)
            OP_LOAD: begin
              if (in_data_i.node_a == '0 || in_data_i.node_b == '0) begin
                res_d.status = ST_BAD_ID;
                state_d      = S_DONE;
              end else if (used_q > FULL_AT) begin
                res_d.status = ST_FULL;
                state_d      = S_DONE;
              end else begin
                state_d = S_LA1;
              end
            end
            OP_BUILD: begin
              if (root_q == '0) begin
                res_d.status = ST_BAD_ID;
                state_d      = S_DONE;
              end else begin
                clr_cnt_d = '0;
                state_d   = S_CLR;
              end
            end
            OP_QUERY: begin
              if (in_data_i.node_a == '0 || in_data_i.node_b == '0) begin
                res_d.status = ST_BAD_ID;
                state_d      = S_DONE;
              end else if (!built_q) begin
                res_d.status = ST_NO_BUILD;
                state_d      = S_DONE;
              end else begin
                state_d = S_QRD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_LA1: state_d = S_LA2;
      S_LA2: begin
        used_d  = used_q + LINK_W'(1);
        state_d = S_LB1;
      end
      S_LB1: state_d = S_LB2;
      S_LB2: begin
        used_d  = used_q + LINK_W'(1);
        state_d = S_DONE;
      end
      S_BROOT: state_d = S_BROOT2;
      S_BROOT2: begin
        top_d.node = root_q;
        top_d.cur  = head_rdata;
        top_d.dep  = NODE_W'(1);
        sp_d       = '0;
        state_d    = S_BTOP;
      end
      S_BTOP: begin
        if (top_q.cur == '0) begin
          if (sp_q == '0) begin
            built_d = 1'b1;
            state_d = S_DONE;
          end else begin
            sp_d    = sp_q - NODE_W'(1);
            state_d = S_BPOP;
          end
        end else begin
          state_d = S_BEDGE;
        end
      end
      S_BPOP: begin
        top_d   = stack_rdata;
        state_d = S_BTOP;
      end
      S_BEDGE: begin
        top_d.cur = next_rdata;
        t_d       = tgt_rdata;
        state_d   = S_BVIS;
      end
      S_BVIS: begin
        if (rdata_a.visited) begin
          state_d = S_BTOP;
        end else begin
          new_anc_d    = '0;
          new_anc_d[0] = top_q.node;
          new_cur_d    = head_rdata;
          lvl_d        = LVL_W'(1);
          state_d      = S_BANC;
        end
      end
      S_BANC: begin
        // An ancestor of zero means every higher entry stays zero.
        if (new_anc_q[lvl_q - LVL_W'(1)] == '0) state_d = S_BWR;
        else state_d = S_BANCW;
      end
      S_BANCW: begin
        new_anc_d[lvl_q] = rdata_a.anc[lvl_q - LVL_W'(1)];
        if (lvl_q == LVL_TOP) begin
          state_d = S_BWR;
        end else begin
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = S_BANC;
        end
      end
      S_BWR: begin
        sp_d       = sp_q + NODE_W'(1);
        top_d.node = t_q;
        top_d.cur  = new_cur_q;
        top_d.dep  = top_q.dep + NODE_W'(1);
        state_d    = S_BTOP;
      end
      S_QRD: state_d = S_QSW;
      S_QSW: begin
        if (rdata_a.depth > rdata_b.depth) begin
          u_d = b_q; row_u_d = rdata_b;
          v_d = a_q; row_v_d = rdata_a;
          dist_d = LEVELS'(rdata_a.depth - rdata_b.depth);
        end else begin
          u_d = a_q; row_u_d = rdata_a;
          v_d = b_q; row_v_d = rdata_b;
          dist_d = LEVELS'(rdata_b.depth - rdata_a.depth);
        end
        lvl_d   = '0;
        state_d = S_QLIFT;
      end
      S_QLIFT: begin
        if (dist_q[lvl_q]) begin
          v_d     = row_v_q.anc[lvl_q];
          state_d = S_QLIFTW;
        end else if (lvl_q == LVL_TOP) begin
          state_d = S_QCMP;
        end else begin
          lvl_d = lvl_q + LVL_W'(1);
        end
      end
      S_QLIFTW: begin
        row_v_d = rdata_b;
        if (lvl_q == LVL_TOP) begin
          state_d = S_QCMP;
        end else begin
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = S_QLIFT;
        end
      end
      S_QCMP: begin
        if (u_q == v_q) begin
          res_d.ancestor = u_q;
          state_d        = S_DONE;
        end else begin
          lvl_d   = LVL_TOP;
          state_d = S_QDESC;
        end
      end
      S_QDESC: begin
        if (row_u_q.anc[lvl_q] != row_v_q.anc[lvl_q]) begin
          state_d = S_QDESCW;
        end else if (lvl_q == '0) begin
          state_d = S_QFIN;
        end else begin
          lvl_d = lvl_q - LVL_W'(1);
        end
      end
      S_QDESCW: begin
        row_u_d = rdata_a;
        row_v_d = rdata_b;
        if (lvl_q == '0) begin
          state_d = S_QFIN;
        end else begin
          lvl_d   = lvl_q - LVL_W'(1);
          state_d = S_QDESC;
        end
      end
      S_QFIN: begin
        res_d.ancestor = row_u_q.anc[0];
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_head_q  <= 1'b1;
      clr_cnt_q   <= '0;
      root_q      <= NODE_W'(1);
      built_q     <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      sp_q        <= '0;
      lvl_q       <= '0;
    end else begin
      state_q    <= state_d;
      clr_head_q <= clr_head_d;
      clr_cnt_q  <= clr_cnt_d;
      built_q    <= built_d;
      used_q     <= used_d;
      sp_q       <= sp_d;
      lvl_q      <= lvl_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the sequencer and the output beat.
  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    res_q     <= res_d;
    top_q     <= top_d;
    t_q       <= t_d;
    new_cur_q <= new_cur_d;
    new_anc_q <= new_anc_d;
    u_q       <= u_d;
    v_q       <= v_d;
    row_u_q   <= row_u_d;
    row_v_q   <= row_v_d;
    dist_q    <= dist_d;
    if (state_q == S_DONE && out_free) begin
      out_q <= res_q;
    end
  end

endmodule

// File: test/testbench.sv
// Self-checking testbench for the binary-lifting common-ancestor engine.
`timescale 1ns / 1ps

module testbench;
  import tlca_pkg::*;

  localparam int DOG_LIMIT = 200000;

  logic  clk_i;
  logic  rst_ni;
  logic  cfg_we_i;
  node_t cfg_wdata_i;
  logic  in_valid_i;
  logic  in_stall_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_stall_i;
  out_t  out_data_o;

  tree_lca_binary_lifting_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Shadow copy of the engine's state.
  link_t lk_head [NODES];
  link_t lk_next [EDGE_SLOTS];
  node_t lk_target [EDGE_SLOTS];
  int unsigned slots_used;
  bit    seen [NODES];
  node_t depth_of [NODES];
  node_t anc_of [NODES][LEVELS];
  node_t stk_node [NODES];
  link_t stk_cur [NODES];
  bit    built;
  node_t root_cfg;

  in_t  pending_beats [$];
  out_t awaited_results [$];
  int   send_idle;
  int   recv_idle;
  int   errors;
  int   quiet_cycles;
  int   op_count [4];
  int   status_count [4];
  int   builds_done;

  node_t tree_ids [$];
  bit    in_tree [NODES];

  function automatic bit id_good(node_t x);
    return x != 0;
  endfunction

  function automatic void mark_node(node_t n);
    seen[n] = 1'b1;
    for (int i = 1; i < LEVELS; i++) begin
      anc_of[n][i] = anc_of[anc_of[n][i-1]][i-1];
    end
  endfunction

  function automatic void store_link(node_t a, node_t b);
    lk_next[slots_used] = lk_head[a];
    lk_target[slots_used] = b;
    lk_head[a] = link_t'(slots_used + 1);
    slots_used++;
  endfunction

  function automatic void grow_tables(node_t r);
    int sp;
    int slot;
    node_t t;
    node_t parent;
    for (int n = 0; n < NODES; n++) begin
      seen[n] = 1'b0;
      depth_of[n] = '0;
      for (int l = 0; l < LEVELS; l++) anc_of[n][l] = '0;
    end
    depth_of[r] = 1;
    mark_node(r);
    stk_node[0] = r;
    stk_cur[0] = lk_head[r];
    sp = 1;
    while (sp > 0) begin
      if (stk_cur[sp-1] == 0 || stk_cur[sp-1] > EDGE_SLOTS) begin
        sp--;
        continue;
      end
      slot = int'(stk_cur[sp-1]) - 1;
      stk_cur[sp-1] = lk_next[slot];
      t = lk_target[slot];
      if (seen[t]) continue;
      parent = stk_node[sp-1];
      anc_of[t][0] = parent;
      depth_of[t] = depth_of[parent] + 1'b1;
      mark_node(t);
      if (sp < NODES) begin
        stk_node[sp] = t;
        stk_cur[sp] = lk_head[t];
        sp++;
      end
    end
    built = 1'b1;
  endfunction

  function automatic node_t meet_point(node_t u, node_t v);
    node_t tmp;
    int gap;
    if (depth_of[u] > depth_of[v]) begin
      tmp = u;
      u = v;
      v = tmp;
    end
    gap = int'(depth_of[v]) - int'(depth_of[u]);
    for (int i = 0; i < LEVELS; i++) begin
      if ((gap >> i) & 1) v = anc_of[v][i];
    end
    if (u == v) return u;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (anc_of[u][i] != anc_of[v][i]) begin
        u = anc_of[u][i];
        v = anc_of[v][i];
      end
    end
    return anc_of[u][0];
  endfunction

  function automatic out_t predict_result(in_t beat);
    out_t res;
    res.ancestor = '0;
    res.status = ST_OK;
    case (beat.opcode)
      OP_LOAD: begin
        if (!id_good(beat.node_a) || !id_good(beat.node_b)) begin
          res.status = ST_BAD_ID;
        end else if (slots_used + 2 > EDGE_SLOTS) begin
          res.status = ST_FULL;
        end else begin
          store_link(beat.node_a, beat.node_b);
          store_link(beat.node_b, beat.node_a);
        end
      end
      OP_BUILD: begin
        if (!id_good(root_cfg)) res.status = ST_BAD_ID;
        else grow_tables(root_cfg);
      end
      OP_QUERY: begin
        if (!id_good(beat.node_a) || !id_good(beat.node_b)) res.status = ST_BAD_ID;
        else if (!built) res.status = ST_NO_BUILD;
        else res.ancestor = meet_point(beat.node_a, beat.node_b);
      end
      default: ;
    endcase
    return res;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Driver: takes the accepted beat into the prediction, then offers the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        awaited_results.push_back(predict_result(in_data_i));
        op_count[in_data_i.opcode]++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_data_i <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each delivered beat against the oldest prediction.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          status_count[out_data_o.status]++;
          if (out_data_o.ancestor !== want.ancestor) begin
            $display("%0t: ancestor mismatch, expected %0d, actual %0d", $time,
                     want.ancestor, out_data_o.ancestor);
            errors++;
          end
          if (out_data_o.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, out_data_o.status);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= DOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put(logic [1:0] op, node_t a, node_t b);
    in_t beat;
    beat.opcode = op;
    beat.node_a = a;
    beat.node_b = b;
    pending_beats.push_back(beat);
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || awaited_results.size() != 0 || in_valid_i)
      @(posedge clk_i);
  endtask

  task automatic set_root(node_t r);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    root_cfg = r;
  endtask

  function automatic node_t any_tree_node();
    return tree_ids[$urandom_range(tree_ids.size() - 1)];
  endfunction

  // Mostly grows one tree and queries inside it; the rest is noise.
  task automatic add_random_beat();
    int pick;
    node_t a;
    node_t b;
    pick = $urandom_range(99);
    if (pick < 70) begin
      if ($urandom_range(99) < 85) begin
        a = any_tree_node();
        b = node_t'($urandom_range(1, NODES - 1));
        if (!in_tree[b]) begin
          in_tree[b] = 1'b1;
          tree_ids.push_back(b);
        end
        if ($urandom_range(1)) put(OP_LOAD, a, b);
        else put(OP_LOAD, b, a);
      end else begin
        a = node_t'($urandom_range(NODES - 1));
        b = ($urandom_range(3) == 0) ? a : node_t'($urandom_range(NODES - 1));
        put(OP_LOAD, a, b);
      end
    end else if (pick < 72) begin
      put(OP_BUILD, node_t'($urandom), node_t'($urandom));
    end else if (pick < 97) begin
      if ($urandom_range(99) < 80) begin
        a = any_tree_node();
        b = ($urandom_range(9) == 0) ? a : any_tree_node();
      end else begin
        a = node_t'($urandom_range(NODES - 1));
        b = node_t'($urandom_range(NODES - 1));
      end
      put(OP_QUERY, a, b);
    end else begin
      put(2'd3, node_t'($urandom), node_t'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    builds_done = 0;
    send_idle = 19;
    recv_idle = 54;
    for (int i = 0; i < 4; i++) begin
      op_count[i] = 0;
      status_count[i] = 0;
    end
    for (int n = 0; n < NODES; n++) begin
      lk_head[n] = '0;
      seen[n] = 1'b0;
      depth_of[n] = '0;
      in_tree[n] = 1'b0;
      for (int l = 0; l < LEVELS; l++) anc_of[n][l] = '0;
    end
    for (int s = 0; s < EDGE_SLOTS; s++) begin
      lk_next[s] = '0;
      lk_target[s] = '0;
    end
    slots_used = 0;
    built = 1'b0;
    root_cfg = 1;
    tree_ids.push_back(node_t'(1));
    in_tree[1] = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Queries before any build, zero ids, ignored opcode, then loads of a small tree.
    put(OP_QUERY, 5, 6);
    put(OP_QUERY, 0, 3);
    put(OP_QUERY, 1023, 0);
    put(OP_LOAD, 0, 4);
    put(OP_LOAD, 4, 0);
    put(2'd3, 1023, 1023);
    put(OP_LOAD, 1, 2);
    put(OP_LOAD, 2, 3);
    put(OP_LOAD, 1023, 1);
    put(OP_LOAD, 3, 3);
    put(OP_LOAD, 2, 3);
    put(OP_LOAD, 3, 1);
    foreach (tree_ids[i]) ;
    tree_ids.push_back(node_t'(2));
    tree_ids.push_back(node_t'(3));
    tree_ids.push_back(node_t'(1023));
    in_tree[2] = 1'b1;
    in_tree[3] = 1'b1;
    in_tree[1023] = 1'b1;
    // A build with the root register at zero is refused.
    set_root(0);
    put(OP_BUILD, 0, 0);
    put(OP_QUERY, 2, 3);
    set_root(1);
    put(OP_BUILD, 0, 0);
    put(OP_QUERY, 2, 3);
    put(OP_QUERY, 1023, 3);
    put(OP_QUERY, 1, 1);
    put(OP_QUERY, 700, 700);
    put(OP_QUERY, 700, 2);
    set_root(1023);
    put(OP_BUILD, 0, 0);
    put(OP_QUERY, 2, 3);
    put(OP_QUERY, 1, 1022);

    for (int phase = 0; phase < 3; phase++) begin
      set_root(phase == 1 ? node_t'(1023) : any_tree_node());
      send_idle = (phase == 0) ? 19 : (phase == 1) ? 54 : 0;
      recv_idle = (phase == 0) ? 54 : (phase == 1) ? 19 : 0;
      repeat (515) add_random_beat();
      put(OP_BUILD, 0, 0);
      put(OP_QUERY, any_tree_node(), any_tree_node());
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    $display("beats sent: %0d loads, %0d builds, %0d queries, %0d ignored; %0d edge slots used",
             op_count[0], op_count[1], op_count[2], op_count[3], slots_used);
    $display("results by status: ok %0d, store full %0d, bad id %0d, not built %0d",
             status_count[0], status_count[1], status_count[2], status_count[3]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tlca_pkg.sv
rtl/tlca_node_ram.sv
rtl/tree_lca_binary_lifting_unit.sv
test/testbench.sv
